// ----- rtl/core/tpdr_pkg.sv -----
// shared types and constants of the triangle pixel depth raster unit
package tpdr_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic [15:0] FAR_DEPTH = 16'hFFFF;

  // product steps: four groups of three for area and edges, three for depth sum
  localparam logic [3:0] STEP_LAST_EDGE = 4'd11;
  localparam logic [3:0] STEP_FIRST_NUM = 4'd12;
  localparam logic [3:0] STEP_LAST      = 4'd14;

  // quotient slots
  localparam logic [1:0] DIV_ALPHA = 2'd0;
  localparam logic [1:0] DIV_BETA  = 2'd1;
  localparam logic [1:0] DIV_GAMMA = 2'd2;
  localparam logic [1:0] DIV_DEPTH = 2'd3;

  // register indexes
  localparam logic CFG_VIEW_WIDTH  = 1'b0;
  localparam logic CFG_VIEW_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_CULLED     = 2'd0,
    ST_OUTSIDE    = 2'd1,
    ST_DEPTH_FAIL = 2'd2,
    ST_WRITTEN    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL_EDGE,
    S_DRAIN_EDGE,
    S_CHECK,
    S_MUL_NUM,
    S_DRAIN_NUM,
    S_DIV_START,
    S_DIV_WAIT,
    S_READ,
    S_COMPARE,
    S_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic       clr;
    logic       load;
    logic       mul_en;
    logic [3:0] step;
    logic       div_start;
    logic [1:0] div_sel;
    logic       cmp_en;
    logic       fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cull;
    logic outside;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

endpackage

// ----- rtl/core/triangle_pixel_depth_raster_unit.sv -----
// top level of the triangle pixel depth raster unit
//
// one input transaction carries a triangle (three vertices with depth) and a
// candidate pixel; one result transaction comes back for each of them
// status: culled, outside, depth fail or written, with barycentrics and depth
// a shared multiplier walks the area and edge products, one a cycle
// culled or outside pixels go from the edge products and the check straight
// to the result; covered pixels then take the depth sum products, four
// divisions (start plus 16 quotient bits each) in the restoring divider,
// then a depth read and compare on the buffer ports
// one transaction is in work at a time; the next is taken as soon as the
// result sits in the output register, even while out_ready is low
// a stalled receiver holds the result; the block stalls in its final step
// only when a second result is ready before the first is taken
// after reset the depth buffer is swept to the far value, one entry a cycle,
// MAX_WIDTH*MAX_HEIGHT entries (65536 by default); in_ready is low meanwhile
// configuration writes are taken at any time, intended while idle
module triangle_pixel_depth_raster_unit #(
  parameter int MAX_WIDTH  = tpdr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tpdr_pkg::DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [11:0] in_vert0_x,
  input  logic signed [11:0] in_vert0_y,
  input  logic [15:0]        in_vert0_depth,
  input  logic signed [11:0] in_vert1_x,
  input  logic signed [11:0] in_vert1_y,
  input  logic [15:0]        in_vert1_depth,
  input  logic signed [11:0] in_vert2_x,
  input  logic signed [11:0] in_vert2_y,
  input  logic [15:0]        in_vert2_depth,
  input  logic [7:0]         in_pixel_x,
  input  logic [7:0]         in_pixel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [15:0]        out_bary_alpha,
  output logic [15:0]        out_bary_beta,
  output logic [15:0]        out_bary_gamma,
  output logic [15:0]        out_frag_depth,
  output logic [7:0]         out_frag_x,
  output logic [7:0]         out_frag_y
);

  // command and status between sequencer and datapath
  tpdr_pkg::ctl_cmd_t cmd;
  tpdr_pkg::dp_stat_t stat;

  tpdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tpdr_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_vert0_x     (in_vert0_x),
    .in_vert0_y     (in_vert0_y),
    .in_vert0_depth (in_vert0_depth),
    .in_vert1_x     (in_vert1_x),
    .in_vert1_y     (in_vert1_y),
    .in_vert1_depth (in_vert1_depth),
    .in_vert2_x     (in_vert2_x),
    .in_vert2_y     (in_vert2_y),
    .in_vert2_depth (in_vert2_depth),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_bary_alpha (out_bary_alpha),
    .out_bary_beta  (out_bary_beta),
    .out_bary_gamma (out_bary_gamma),
    .out_frag_depth (out_frag_depth),
    .out_frag_x     (out_frag_x),
    .out_frag_y     (out_frag_y)
  );

`ifndef SYNTHESIS
  // rejected fragments carry zero weights and depth
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == tpdr_pkg::ST_CULLED || out_status == tpdr_pkg::ST_OUTSIDE)
    |-> (out_bary_alpha == 16'd0 && out_bary_beta == 16'd0 &&
         out_bary_gamma == 16'd0 && out_frag_depth == 16'd0))
    else $error("rejected fragment with nonzero payload");

  // a written fragment is strictly nearer than the far value
  a_written_near: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tpdr_pkg::ST_WRITTEN |-> out_frag_depth != tpdr_pkg::FAR_DEPTH)
    else $error("far fragment reported as written");

  // weights never exceed one
  a_bary_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bary_alpha <= 16'd32768 && out_bary_beta <= 16'd32768 &&
                   out_bary_gamma <= 16'd32768))
    else $error("barycentric weight above one");
`endif

endmodule

// ----- rtl/core/tpdr_ram.sv -----
// generic simple dual port ram with registered read
module tpdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/tpdr_ctrl.sv -----
// sequencer of the raster unit
module tpdr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tpdr_pkg::dp_stat_t stat,
  output tpdr_pkg::ctl_cmd_t cmd
);

  tpdr_pkg::ctl_state_t state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [1:0] sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpdr_pkg::S_CLEAR;
      step_r  <= '0;
      sel_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.step  = step_r;
    cmd.div_sel = sel_r;
    in_ready  = 1'b0;
    case (state_r)
      tpdr_pkg::S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = tpdr_pkg::S_IDLE;
        end
      end
      tpdr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = tpdr_pkg::S_MUL_EDGE;
        end
      end
      tpdr_pkg::S_MUL_EDGE: begin
        cmd.mul_en = 1'b1;
        step_nxt   = step_r + 4'd1;
        if (step_r == tpdr_pkg::STEP_LAST_EDGE) begin
          state_nxt = tpdr_pkg::S_DRAIN_EDGE;
        end
      end
      tpdr_pkg::S_DRAIN_EDGE: begin
        state_nxt = tpdr_pkg::S_CHECK;
      end
      tpdr_pkg::S_CHECK: begin
        if (stat.cull || stat.outside) begin
          state_nxt = tpdr_pkg::S_FINISH;
        end else begin
          step_nxt  = tpdr_pkg::STEP_FIRST_NUM;
          state_nxt = tpdr_pkg::S_MUL_NUM;
        end
      end
      tpdr_pkg::S_MUL_NUM: begin
        cmd.mul_en = 1'b1;
        step_nxt   = step_r + 4'd1;
        if (step_r == tpdr_pkg::STEP_LAST) begin
          state_nxt = tpdr_pkg::S_DRAIN_NUM;
        end
      end
      tpdr_pkg::S_DRAIN_NUM: begin
        sel_nxt   = tpdr_pkg::DIV_ALPHA;
        state_nxt = tpdr_pkg::S_DIV_START;
      end
      tpdr_pkg::S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = tpdr_pkg::S_DIV_WAIT;
      end
      tpdr_pkg::S_DIV_WAIT: begin
        if (stat.div_done) begin
          if (sel_r == tpdr_pkg::DIV_DEPTH) begin
            state_nxt = tpdr_pkg::S_READ;
          end else begin
            sel_nxt   = sel_r + 2'd1;
            state_nxt = tpdr_pkg::S_DIV_START;
          end
        end
      end
      tpdr_pkg::S_READ: begin
        state_nxt = tpdr_pkg::S_COMPARE;
      end
      tpdr_pkg::S_COMPARE: begin
        cmd.cmp_en = 1'b1;
        state_nxt  = tpdr_pkg::S_FINISH;
      end
      tpdr_pkg::S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = tpdr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tpdr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/tpdr_dp.sv -----
// datapath: edge products, divider, depth buffer and result register
module tpdr_dp #(
  parameter int MAX_WIDTH  = tpdr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tpdr_pkg::DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tpdr_pkg::ctl_cmd_t cmd,
  output tpdr_pkg::dp_stat_t stat,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_wdata,
  input  logic signed [11:0] in_vert0_x,
  input  logic signed [11:0] in_vert0_y,
  input  logic [15:0]        in_vert0_depth,
  input  logic signed [11:0] in_vert1_x,
  input  logic signed [11:0] in_vert1_y,
  input  logic [15:0]        in_vert1_depth,
  input  logic signed [11:0] in_vert2_x,
  input  logic signed [11:0] in_vert2_y,
  input  logic [15:0]        in_vert2_depth,
  input  logic [7:0]         in_pixel_x,
  input  logic [7:0]         in_pixel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [15:0]        out_bary_alpha,
  output logic [15:0]        out_bary_beta,
  output logic [15:0]        out_bary_gamma,
  output logic [15:0]        out_frag_depth,
  output logic [7:0]         out_frag_x,
  output logic [7:0]         out_frag_y
);

  localparam int SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = $clog2(SIZE);

  logic [8:0] view_w_r, view_h_r;

  logic signed [11:0] x0_r, y0_r, x1_r, y1_r, x2_r, y2_r;
  logic [15:0] z0_r, z1_r, z2_r;
  logic [7:0]  px_r, py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_w_r <= 9'd256;
      view_h_r <= 9'd256;
    end else if (cfg_we) begin
      if (cfg_index == tpdr_pkg::CFG_VIEW_WIDTH) begin
        view_w_r <= cfg_wdata;
      end else begin
        view_h_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r <= in_vert0_x; y0_r <= in_vert0_y; z0_r <= in_vert0_depth;
      x1_r <= in_vert1_x; y1_r <= in_vert1_y; z1_r <= in_vert1_depth;
      x2_r <= in_vert2_x; y2_r <= in_vert2_y; z2_r <= in_vert2_depth;
      px_r <= in_pixel_x; py_r <= in_pixel_y;
    end
  end

  // operand selection for the shared multiplier
  logic signed [12:0] v0x, v0y, v1x, v1y, v2x, v2y, pxs, pys;
  logic signed [12:0] ax, ay, bx, by, cx, cy, ux, uy, wx, wy;
  logic signed [13:0] dif, sum;
  logic signed [26:0] opa;
  logic signed [16:0] opb;
  logic signed [25:0] a2_r, ea_r, eb_r, eg_r;
  logic [41:0] num_r;

  assign v0x = 13'(x0_r); assign v0y = 13'(y0_r);
  assign v1x = 13'(x1_r); assign v1y = 13'(y1_r);
  assign v2x = 13'(x2_r); assign v2y = 13'(y2_r);
  assign pxs = signed'({5'b0, px_r});
  assign pys = signed'({5'b0, py_r});

  always_comb begin
    ax = v0x; ay = v0y; bx = v1x; by = v1y; cx = v2x; cy = v2y;
    case (cmd.step)
      4'd3, 4'd4, 4'd5:   begin ax = pxs; ay = pys; end
      4'd6, 4'd7, 4'd8:   begin bx = pxs; by = pys; end
      4'd9, 4'd10, 4'd11: begin cx = pxs; cy = pys; end
      default: ;
    endcase
    // shoelace term picks a pair of corners
    case (cmd.step)
      4'd0, 4'd3, 4'd6, 4'd9:  begin ux = ax; uy = ay; wx = bx; wy = by; end
      4'd1, 4'd4, 4'd7, 4'd10: begin ux = bx; uy = by; wx = cx; wy = cy; end
      default:                 begin ux = cx; uy = cy; wx = ax; wy = ay; end
    endcase
    dif = 14'(wy) - 14'(uy);
    sum = 14'(wx) + 14'(ux);
    case (cmd.step)
      4'd12:   begin opa = 27'(ea_r); opb = signed'({1'b0, z0_r}); end
      4'd13:   begin opa = 27'(eb_r); opb = signed'({1'b0, z1_r}); end
      4'd14:   begin opa = 27'(eg_r); opb = signed'({1'b0, z2_r}); end
      default: begin opa = 27'(dif);  opb = 17'(sum); end
    endcase
  end

  logic signed [43:0] p_r;
  logic [3:0]         pstep_r;
  logic               pv_r;
  logic signed [45:0] acc_r, acc_sum;
  logic               first;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.mul_en;
    end
    p_r     <= opa * opb;
    pstep_r <= cmd.step;
  end

  assign first = (pstep_r == 4'd0) || (pstep_r == 4'd3) || (pstep_r == 4'd6) ||
                 (pstep_r == 4'd9) || (pstep_r == 4'd12);
  assign acc_sum = (first ? 46'sd0 : acc_r) + 46'(p_r);

  always_ff @(posedge clk) begin
    if (pv_r) begin
      acc_r <= acc_sum;
      case (pstep_r)
        4'd2:    a2_r  <= acc_sum[25:0];
        4'd5:    ea_r  <= acc_sum[25:0];
        4'd8:    eb_r  <= acc_sum[25:0];
        4'd11:   eg_r  <= acc_sum[25:0];
        4'd14:   num_r <= acc_sum[41:0];
        default: ;
      endcase
    end
  end

  // restoring divider by the doubled area, one quotient bit a cycle
  logic [15:0] dvd_r, q_r, q_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [3:0]  dcnt_r;
  logic        dbusy_r;
  logic [1:0]  dsel_r;
  logic [41:0] dnum;
  logic [26:0] trial, a2u;
  logic        ge;
  logic [15:0] alpha_r, beta_r, gamma_r, fdepth_r;

  always_comb begin
    case (cmd.div_sel)
      tpdr_pkg::DIV_ALPHA: dnum = 42'(ea_r) << 15;
      tpdr_pkg::DIV_BETA:  dnum = 42'(eb_r) << 15;
      tpdr_pkg::DIV_GAMMA: dnum = 42'(eg_r) << 15;
      default:             dnum = num_r;
    endcase
  end

  assign a2u     = 27'(unsigned'(a2_r));
  assign trial   = {rem_r, dvd_r[15]};
  assign ge      = trial >= a2u;
  assign rem_nxt = ge ? 26'(trial - a2u) : trial[25:0];
  assign q_nxt   = {q_r[14:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
    end else if (dbusy_r && dcnt_r == 4'd15) begin
      dbusy_r <= 1'b0;
    end
    if (cmd.div_start) begin
      rem_r  <= dnum[41:16];
      dvd_r  <= dnum[15:0];
      dcnt_r <= '0;
      dsel_r <= cmd.div_sel;
    end else if (dbusy_r) begin
      rem_r  <= rem_nxt;
      dvd_r  <= {dvd_r[14:0], 1'b0};
      q_r    <= q_nxt;
      dcnt_r <= dcnt_r + 4'd1;
      if (dcnt_r == 4'd15) begin
        case (dsel_r)
          tpdr_pkg::DIV_ALPHA: alpha_r  <= q_nxt;
          tpdr_pkg::DIV_BETA:  beta_r   <= q_nxt;
          tpdr_pkg::DIV_GAMMA: gamma_r  <= q_nxt;
          default:             fdepth_r <= q_nxt;
        endcase
      end
    end
  end

  // depth buffer with clearing sweep
  logic [AW-1:0] clr_addr_r, idx, waddr;
  logic [15:0]   rdata, wdata;
  logic          we, less, pass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign idx   = AW'(32'(py_r) * MAX_WIDTH + 32'(px_r));
  assign less  = fdepth_r < rdata;
  assign we    = cmd.clr || (cmd.cmp_en && less);
  assign waddr = cmd.clr ? clr_addr_r : idx;
  assign wdata = cmd.clr ? tpdr_pkg::FAR_DEPTH : fdepth_r;

  tpdr_ram #(.WIDTH(16), .DEPTH(SIZE)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      pass_r <= less;
    end
  end

  // result register
  logic        out_vld_r;
  logic [1:0]  st_r;
  logic [15:0] o_alpha_r, o_beta_r, o_gamma_r, o_depth_r;
  logic [7:0]  o_x_r, o_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.fin) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
    if (cmd.fin) begin
      o_x_r <= px_r;
      o_y_r <= py_r;
      if (stat.cull || stat.outside) begin
        st_r      <= stat.cull ? tpdr_pkg::ST_CULLED : tpdr_pkg::ST_OUTSIDE;
        o_alpha_r <= '0;
        o_beta_r  <= '0;
        o_gamma_r <= '0;
        o_depth_r <= '0;
      end else begin
        st_r      <= pass_r ? tpdr_pkg::ST_WRITTEN : tpdr_pkg::ST_DEPTH_FAIL;
        o_alpha_r <= alpha_r;
        o_beta_r  <= beta_r;
        o_gamma_r <= gamma_r;
        o_depth_r <= fdepth_r;
      end
    end
  end

  assign stat.clr_last = (32'(clr_addr_r) == SIZE - 1);
  assign stat.cull     = a2_r <= 26'sd1;
  assign stat.outside  = (px_r >= 8'(view_w_r) && view_w_r[8] == 1'b0) ||
                         (py_r >= 8'(view_h_r) && view_h_r[8] == 1'b0) ||
                         (32'(px_r) >= MAX_WIDTH) || (32'(py_r) >= MAX_HEIGHT) ||
                         ea_r[25] || eb_r[25] || eg_r[25];
  assign stat.div_done = dbusy_r && (dcnt_r == 4'd15);
  assign stat.out_busy = out_vld_r && !out_ready;

  assign out_valid      = out_vld_r;
  assign out_status     = st_r;
  assign out_bary_alpha = o_alpha_r;
  assign out_bary_beta  = o_beta_r;
  assign out_bary_gamma = o_gamma_r;
  assign out_frag_depth = o_depth_r;
  assign out_frag_x     = o_x_r;
  assign out_frag_y     = o_y_r;

endmodule

// ----- tb/sv/tb.sv -----
// testbench of the triangle pixel depth raster unit: random and directed fragments
`timescale 1ns / 100ps

// keeps the depth buffer copy and the queue of expected fragments
class frag_scoreboard;
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] alpha;
    logic [15:0] beta;
    logic [15:0] gamma;
    logic [15:0] depth;
    logic [7:0]  x;
    logic [7:0]  y;
  } frag_t;

  frag_t        pending_frags[$];
  logic [15:0]  zbuf[65536];
  int unsigned  view_w;
  int unsigned  view_h;
  int           errors;

  function new();
    foreach (zbuf[i]) zbuf[i] = tpdr_pkg::FAR_DEPTH;
    view_w = 256;
    view_h = 256;
    errors = 0;
  endfunction

  function void set_view(logic idx, logic [8:0] val);
    if (idx == tpdr_pkg::CFG_VIEW_WIDTH) view_w = val;
    else view_h = val;
  endfunction

  function longint shoelace(longint ax, longint ay, longint bx, longint by,
                            longint cx, longint cy);
    return (by - ay) * (bx + ax) + (cy - by) * (cx + bx) + (ay - cy) * (ax + cx);
  endfunction

  // predict the fragment for one accepted triangle and pixel
  function void note_triangle(logic signed [11:0] x0, logic signed [11:0] y0,
                              logic [15:0] z0, logic signed [11:0] x1,
                              logic signed [11:0] y1, logic [15:0] z1,
                              logic signed [11:0] x2, logic signed [11:0] y2,
                              logic [15:0] z2, logic [7:0] px, logic [7:0] py);
    frag_t f;
    longint a2, ea, eb, eg, d;
    int unsigned aw, ah, idx;
    f = '0;
    f.x = px;
    f.y = py;
    a2 = shoelace(x0, y0, x1, y1, x2, y2);
    if (a2 <= 1) begin
      f.status = tpdr_pkg::ST_CULLED;
    end else begin
      aw = view_w < 256 ? view_w : 256;
      ah = view_h < 256 ? view_h : 256;
      ea = shoelace(px, py, x1, y1, x2, y2);
      eb = shoelace(x0, y0, px, py, x2, y2);
      eg = shoelace(x0, y0, x1, y1, px, py);
      if (px >= aw || py >= ah || ea < 0 || eb < 0 || eg < 0) begin
        f.status = tpdr_pkg::ST_OUTSIDE;
      end else begin
        d = (ea * z0 + eb * z1 + eg * z2) / a2;
        f.alpha = (ea * 32768) / a2;
        f.beta = (eb * 32768) / a2;
        f.gamma = (eg * 32768) / a2;
        f.depth = d;
        idx = py * 256 + px;
        if (d < zbuf[idx]) begin
          zbuf[idx] = d;
          f.status = tpdr_pkg::ST_WRITTEN;
        end else begin
          f.status = tpdr_pkg::ST_DEPTH_FAIL;
        end
      end
    end
    pending_frags.push_back(f);
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task check_frag(frag_t got);
    frag_t w;
    if (pending_frags.size() == 0) begin
      report("unexpected fragment", got.status, -1);
      return;
    end
    w = pending_frags.pop_front();
    if (got.status != w.status) report("status", got.status, w.status);
    if (got.alpha != w.alpha) report("bary_alpha", got.alpha, w.alpha);
    if (got.beta != w.beta) report("bary_beta", got.beta, w.beta);
    if (got.gamma != w.gamma) report("bary_gamma", got.gamma, w.gamma);
    if (got.depth != w.depth) report("frag_depth", got.depth, w.depth);
    if (got.x != w.x) report("frag_x", got.x, w.x);
    if (got.y != w.y) report("frag_y", got.y, w.y);
  endtask
endclass

module tb;

  logic clk, rst_n;
  logic cfg_we, cfg_index;
  logic [8:0] cfg_wdata;
  logic in_valid, in_ready;
  logic signed [11:0] in_vert0_x, in_vert0_y, in_vert1_x, in_vert1_y;
  logic signed [11:0] in_vert2_x, in_vert2_y;
  logic [15:0] in_vert0_depth, in_vert1_depth, in_vert2_depth;
  logic [7:0] in_pixel_x, in_pixel_y;
  logic out_valid, out_ready;
  logic [1:0] out_status;
  logic [15:0] out_bary_alpha, out_bary_beta, out_bary_gamma, out_frag_depth;
  logic [7:0] out_frag_x, out_frag_y;

  frag_scoreboard sb;
  int idle_pct;        // percent chance of an idle cycle on each side
  bit hold_sink;       // receiver holds off while this is set
  int quiet_cycles;    // cycles with no transaction, for the watchdog

  triangle_pixel_depth_raster_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: its limit on quiet cycles must cover the clearing sweep after reset
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 200000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sample accepted results at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_frag({out_status, out_bary_alpha, out_bary_beta, out_bary_gamma,
                     out_frag_depth, out_frag_x, out_frag_y});
  end

  // receiver: random stalls, plus a long hold when asked
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_sink && ($urandom_range(99) >= idle_pct);
  end

  // register write, only called while the block is idle
  task automatic write_reg(logic idx, logic [8:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_view(idx, val);
  endtask

  // offer one triangle and pixel, hold until the transaction is taken
  task automatic send_triangle(logic signed [11:0] x0, y0, logic [15:0] z0,
                               logic signed [11:0] x1, y1, logic [15:0] z1,
                               logic signed [11:0] x2, y2, logic [15:0] z2,
                               logic [7:0] px, py);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_vert0_x <= x0; in_vert0_y <= y0; in_vert0_depth <= z0;
    in_vert1_x <= x1; in_vert1_y <= y1; in_vert1_depth <= z1;
    in_vert2_x <= x2; in_vert2_y <= y2; in_vert2_depth <= z2;
    in_pixel_x <= px; in_pixel_y <= py;
    do @(posedge clk); while (!in_ready);
    sb.note_triangle(x0, y0, z0, x1, y1, z1, x2, y2, z2, px, py);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // wait for every expected fragment, then let a late result surface
  task automatic drain();
    while (sb.pending_frags.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  // small counter-clockwise triangle near the pixel, random content
  task automatic send_random_triangle(int span);
    int cx, cy;
    logic signed [11:0] x0, y0, x1, y1, x2, y2;
    logic [7:0] px, py;
    cx = $urandom_range(255);
    cy = $urandom_range(255);
    x0 = 12'(cx - $urandom_range(span)); y0 = 12'(cy - $urandom_range(span));
    x1 = 12'(cx + $urandom_range(span)); y1 = 12'(cy - $urandom_range(span));
    x2 = 12'(cx + $urandom_range(span) - span / 2); y2 = 12'(cy + $urandom_range(span));
    px = 8'(cx + $urandom_range(4) - 2);
    py = 8'(cy + $urandom_range(4) - 2);
    // orientation with positive area in this formula needs a swap half the time
    if ($urandom_range(1)) begin
      x1 = x0 + x2 - x1;
    end
    if (sb.shoelace(x0, y0, x1, y1, x2, y2) < 0)
      send_triangle(x0, y0, 16'($urandom), x2, y2, 16'($urandom), x1, y1, 16'($urandom),
                    px, py);
    else
      send_triangle(x0, y0, 16'($urandom), x1, y1, 16'($urandom), x2, y2, 16'($urandom),
                    px, py);
  endtask

  task automatic send_noise();
    send_triangle(12'($urandom), 12'($urandom), 16'($urandom),
                  12'($urandom), 12'($urandom), 16'($urandom),
                  12'($urandom), 12'($urandom), 16'($urandom),
                  8'($urandom), 8'($urandom));
  endtask

  initial begin
    logic [8:0] views[6];
    sb = new();
    idle_pct = 9;
    hold_sink = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = 1'b0; cfg_wdata = '0;
    in_valid = 1'b0;
    {in_vert0_x, in_vert0_y, in_vert1_x, in_vert1_y, in_vert2_x, in_vert2_y} = '0;
    {in_vert0_depth, in_vert1_depth, in_vert2_depth} = '0;
    {in_pixel_x, in_pixel_y} = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: large triangle lying just off the screen, corner pixels, edges
    send_triangle(-2048, -2048, 16'h0000, 2047, -2048, 16'hFFFF,
                  -2048, 2047, 16'h8000, 0, 0);
    send_triangle(-2048, -2048, 16'h0000, 2047, -2048, 16'hFFFF,
                  -2048, 2047, 16'h8000, 255, 255);
    send_triangle(0, 0, 16'hFFFF, 255, 0, 16'hFFFF, 0, 255, 16'hFFFF, 10, 10);
    send_triangle(0, 0, 16'h1000, 255, 0, 16'h1000, 0, 255, 16'h1000, 10, 10);
    send_triangle(0, 0, 16'h1000, 255, 0, 16'h1000, 0, 255, 16'h1000, 10, 10);
    send_triangle(0, 0, 16'h0, 8, 0, 16'h0, 0, 8, 16'h0, 8, 0);   // on a vertex
    send_triangle(0, 0, 16'h10, 8, 0, 16'h20, 0, 8, 16'h30, 4, 4); // on an edge
    send_triangle(0, 0, 16'h10, 8, 0, 16'h20, 0, 8, 16'h30, 5, 5); // just outside
    send_triangle(0, 0, 16'h10, 0, 8, 16'h20, 8, 0, 16'h30, 1, 1); // back face
    send_triangle(5, 5, 16'h10, 5, 5, 16'h20, 5, 5, 16'h30, 5, 5); // degenerate
    send_triangle(0, 0, 16'h10, 1, 0, 16'h20, 0, 1, 16'h30, 0, 0); // doubled area one
    send_triangle(0, 0, 16'h10, 2, 0, 16'h20, 0, 1, 16'h30, 0, 0); // doubled area two
    send_triangle(2047, 2047, 16'hFFFF, -2048, 2047, 16'h0, 2047, -2048, 16'h0,
                  128, 128);
    drain();

    // viewport extremes, against the large triangle that leaves both pixels uncovered
    views = '{9'd1, 9'd0, 9'd511, 9'd100, 9'd256, 9'd256};
    for (int v = 0; v < 3; v++) begin
      write_reg(tpdr_pkg::CFG_VIEW_WIDTH, views[2 * v]);
      write_reg(tpdr_pkg::CFG_VIEW_HEIGHT, views[2 * v + 1]);
      send_triangle(-2048, -2048, 16'h100, 2047, -2048, 16'h100,
                    -2048, 2047, 16'h100, 0, 0);
      send_triangle(-2048, -2048, 16'h100, 2047, -2048, 16'h100,
                    -2048, 2047, 16'h100, 99, 150);
      drain();
    end

    // random phases with different viewports
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(tpdr_pkg::CFG_VIEW_WIDTH,
                ph == 5 ? 9'd256 : 9'($urandom_range(1, 300)));
      write_reg(tpdr_pkg::CFG_VIEW_HEIGHT,
                ph == 5 ? 9'd256 : 9'($urandom_range(1, 300)));
      // a long stretch without idling in the middle phase
      idle_pct = (ph == 2) ? 0 : 9;
      if (ph == 3) begin
        // receiver holds off while the sender keeps offering
        fork
          begin
            hold_sink = 1'b1;
            repeat (600) @(negedge clk);
            hold_sink = 1'b0;
          end
          repeat (6) send_random_triangle(16);
        join
      end
      for (int n = 0; n < 300; n++) begin
        if ($urandom_range(9) < 8) send_random_triangle($urandom_range(1, 3) * 12);
        else send_noise();
      end
      drain();  // sender pauses until every fragment has come back
    end

    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
